[src/text_mode_terminal_writer_assert.svh]
// assertion macros used by the terminal writer datapath
`ifndef TEXT_MODE_TERMINAL_WRITER_ASSERT_SVH
`define TEXT_MODE_TERMINAL_WRITER_ASSERT_SVH

// same-cycle implication
`define TMTW_AST_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmtw assertion failed");

// next-cycle implication
`define TMTW_AST_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmtw assertion failed");

`endif

[src/tmtw_pkg.sv]
// types, constants and codes for the text mode terminal writer
`timescale 1ns / 1ps
package tmtw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] BLANK_CHAR  = 8'h20;
  localparam logic [BYTE_W-1:0] RESET_COLOR = 8'h0F;
  localparam logic [BYTE_W-1:0] NL_BYTE     = 8'd10;
  localparam logic [BYTE_W-1:0] BS_BYTE     = 8'd8;

  typedef enum logic [1:0] {
    KIND_PRINT = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_COLOR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ACT,
    ST_FILL,
    ST_RDWAIT,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic load_item;
    logic latch_addr;
    logic fill_wr;
    logic print_wr;
    logic print_upd;
    logic rd_issue;
    logic rd_capture;
    logic rd_blank;
    logic clear_scr;
    logic set_color;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  needs_wr;
    logic  row_ok;
    logic  rd_ok;
    logic  fill_last;
    logic  out_free;
  } dp_stat_t;

endpackage

[src/tmtw_if.sv]
// input and result channel interfaces
`timescale 1ns / 1ps
interface tmtw_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [tmtw_pkg::BYTE_W-1:0]  char_byte;
  logic [tmtw_pkg::BYTE_W-1:0]  new_color;
  logic [tmtw_pkg::ROW_W-1:0]   read_row;
  logic [tmtw_pkg::COL_W-1:0]   read_col;

  modport source (output valid, kind, char_byte, new_color, read_row, read_col,
                  input ready);
  modport sink (input valid, kind, char_byte, new_color, read_row, read_col,
                output ready);
endinterface

interface tmtw_out_if;
  logic                         valid;
  logic                         ready;
  logic [tmtw_pkg::COL_W-1:0]   cursor_col;
  logic [tmtw_pkg::ROW_W-1:0]   cursor_row;
  logic [tmtw_pkg::ADDR_W-1:0]  cursor_pos;
  logic [tmtw_pkg::BYTE_W-1:0]  cell_char;
  logic [tmtw_pkg::BYTE_W-1:0]  cell_attr;
  logic                         did_scroll;

  modport source (output valid, cursor_col, cursor_row, cursor_pos, cell_char,
                  cell_attr, did_scroll, input ready);
  modport sink (input valid, cursor_col, cursor_row, cursor_pos, cell_char,
                cell_attr, did_scroll, output ready);
endinterface

[src/tmtw_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tmtw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/tmtw_ctrl.sv]
// controller state machine sequencing each item
`timescale 1ns / 1ps
module tmtw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tmtw_pkg::dp_stat_t stat,
  output tmtw_pkg::dp_cmd_t  cmd
);
  import tmtw_pkg::*;

  st_t state_r;
  st_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        state_nxt = ST_ACT;
      end
      ST_ACT: begin
        case (stat.kind)
          KIND_PRINT: begin
            if (stat.needs_wr && !stat.row_ok) state_nxt = ST_FILL;
            else state_nxt = ST_DONE;
          end
          KIND_READ: begin
            if (stat.rd_ok && stat.row_ok) state_nxt = ST_RDWAIT;
            else state_nxt = ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_FILL: begin
        if (stat.fill_last) state_nxt = ST_ACT;
      end
      ST_RDWAIT: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_DECODE: begin
        cmd.latch_addr = 1'b1;
      end
      ST_ACT: begin
        case (stat.kind)
          KIND_PRINT: begin
            if (!(stat.needs_wr && !stat.row_ok)) begin
              cmd.print_wr  = stat.needs_wr;
              cmd.print_upd = 1'b1;
            end
          end
          KIND_READ: begin
            cmd.rd_issue = stat.rd_ok && stat.row_ok;
            cmd.rd_blank = stat.rd_ok && !stat.row_ok;
          end
          KIND_CLEAR: begin
            cmd.clear_scr = 1'b1;
          end
          KIND_COLOR: begin
            cmd.set_color = 1'b1;
          end
          default: begin
            cmd.set_color = 1'b0;
          end
        endcase
      end
      ST_FILL: begin
        cmd.fill_wr = 1'b1;
      end
      ST_RDWAIT: begin
        cmd.rd_capture = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[src/tmtw_dp.sv]
// datapath: cursor, scroll offset, row flags, character ram and result register
`timescale 1ns / 1ps
`include "text_mode_terminal_writer_assert.svh"
module tmtw_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tmtw_pkg::dp_cmd_t           cmd,
  output tmtw_pkg::dp_stat_t          stat,
  input  logic [1:0]                  item_kind,
  input  logic [tmtw_pkg::BYTE_W-1:0] item_char_byte,
  input  logic [tmtw_pkg::BYTE_W-1:0] item_new_color,
  input  logic [tmtw_pkg::ROW_W-1:0]  item_read_row,
  input  logic [tmtw_pkg::COL_W-1:0]  item_read_col,
  tmtw_out_if.source                  out_bus
);
  import tmtw_pkg::*;

  // captured item
  kind_t             kind_r;
  logic [BYTE_W-1:0] char_r;
  logic [BYTE_W-1:0] new_color_r;
  logic [ROW_W-1:0]  rrow_r;
  logic [COL_W-1:0]  rcol_r;

  // terminal state
  logic [COL_W-1:0]  cur_col_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic [ROW_W-1:0]  top_r;
  logic [BYTE_W-1:0] color_r;
  logic [ROWS-1:0]   row_valid_r;

  // per item work registers
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] base_r;
  logic [ROW_W-1:0]  prow_r;
  logic [COL_W-1:0]  fill_cnt_r;
  logic [BYTE_W-1:0] cell_char_r;
  logic [BYTE_W-1:0] cell_attr_r;
  logic              scrolled_r;

  // result register
  logic              out_valid_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [ADDR_W-1:0] out_pos_r;
  logic [BYTE_W-1:0] out_char_r;
  logic [BYTE_W-1:0] out_attr_r;
  logic              out_scroll_r;

  logic              is_nl;
  logic              is_bs;
  logic              rd_ok;
  logic              needs_wr;
  logic [ROW_W-1:0]  tgt_row;
  logic [COL_W-1:0]  tgt_col;
  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  prow;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] tgt_addr;

  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic [COL_W-1:0]  cur_col_nxt;
  logic [ROW_W:0]    row_wide;
  logic [ROW_W-1:0]  cur_row_nxt;
  logic              scroll;
  logic [ROW_W-1:0]  top_inc;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;

  // target cell
  always_comb begin
    is_nl    = (char_r == NL_BYTE);
    is_bs    = (char_r == BS_BYTE);
    rd_ok    = (rrow_r < ROW_W'(ROWS)) && ({1'b0, rcol_r} < (COL_W + 1)'(COLUMNS));
    needs_wr = (kind_r == KIND_PRINT) && !is_nl && !(is_bs && (cur_col_r == '0));
    if (kind_r == KIND_READ) begin
      tgt_row = rd_ok ? rrow_r : '0;
      tgt_col = rcol_r;
    end else begin
      tgt_row = cur_row_r;
      tgt_col = is_bs ? cur_col_r - 1'b1 : cur_col_r;
    end
    row_sum  = {1'b0, top_r} + {1'b0, tgt_row};
    prow     = (row_sum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(row_sum - (ROW_W + 1)'(ROWS))
                                                : row_sum[ROW_W-1:0];
    base     = ADDR_W'(prow) * ADDR_W'(COLUMNS);
    tgt_addr = base + ADDR_W'(tgt_col);
  end

  // cursor advance for a printed byte
  always_comb begin
    col_inc     = {1'b0, cur_col_r} + 1'b1;
    row_inc     = {1'b0, cur_row_r} + 1'b1;
    cur_col_nxt = cur_col_r;
    row_wide    = {1'b0, cur_row_r};
    if (is_nl) begin
      cur_col_nxt = '0;
      row_wide    = row_inc;
    end else if (is_bs) begin
      if (cur_col_r != '0) cur_col_nxt = cur_col_r - 1'b1;
    end else if (col_inc >= (COL_W + 1)'(COLUMNS)) begin
      cur_col_nxt = '0;
      row_wide    = row_inc;
    end else begin
      cur_col_nxt = col_inc[COL_W-1:0];
    end
    scroll      = (row_wide >= (ROW_W + 1)'(ROWS));
    cur_row_nxt = scroll ? ROW_W'(ROWS - 1) : row_wide[ROW_W-1:0];
    top_inc     = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r      <= kind_t'(item_kind);
      char_r      <= item_char_byte;
      new_color_r <= item_new_color;
      rrow_r      <= item_read_row;
      rcol_r      <= item_read_col;
    end
    if (cmd.latch_addr) begin
      addr_r <= tgt_addr;
      base_r <= base;
      prow_r <= prow;
    end
    if (cmd.latch_addr) begin
      fill_cnt_r <= '0;
    end else if (cmd.fill_wr) begin
      fill_cnt_r <= fill_cnt_r + 1'b1;
    end
    if (cmd.load_item) begin
      cell_char_r <= '0;
      cell_attr_r <= '0;
      scrolled_r  <= 1'b0;
    end else begin
      if (cmd.rd_blank) begin
        cell_char_r <= BLANK_CHAR;
        cell_attr_r <= color_r;
      end
      if (cmd.rd_capture) begin
        cell_char_r <= ram_rdata;
        cell_attr_r <= color_r;
      end
      if (cmd.print_upd) scrolled_r <= scroll;
    end
    if (cmd.load_out) begin
      out_col_r    <= cur_col_r;
      out_row_r    <= cur_row_r;
      out_pos_r    <= ADDR_W'(cur_row_r) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_r);
      out_char_r   <= cell_char_r;
      out_attr_r   <= cell_attr_r;
      out_scroll_r <= scrolled_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      top_r       <= '0;
      color_r     <= RESET_COLOR;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.print_upd) begin
        cur_col_r <= cur_col_nxt;
        cur_row_r <= cur_row_nxt;
        if (scroll) begin
          top_r              <= top_inc;
          row_valid_r[top_r] <= 1'b0;
        end
      end
      if (cmd.fill_wr && stat.fill_last) begin
        row_valid_r[prow_r] <= 1'b1;
      end
      if (cmd.clear_scr) begin
        cur_col_r   <= '0;
        cur_row_r   <= '0;
        top_r       <= '0;
        row_valid_r <= '0;
      end
      if (cmd.set_color) begin
        color_r <= new_color_r;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ram write: row fill or printed cell
  always_comb begin
    ram_we    = cmd.fill_wr || cmd.print_wr;
    ram_waddr = cmd.fill_wr ? base_r + ADDR_W'(fill_cnt_r) : addr_r;
    ram_wdata = (cmd.fill_wr || is_bs) ? BLANK_CHAR : char_r;
  end

  tmtw_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_issue),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat.kind      = kind_r;
    stat.needs_wr  = needs_wr;
    stat.row_ok    = row_valid_r[prow_r];
    stat.rd_ok     = rd_ok;
    stat.fill_last = (fill_cnt_r == COL_W'(COLUMNS - 1));
    stat.out_free  = !out_valid_r || out_bus.ready;
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.cursor_col = out_col_r;
  assign out_bus.cursor_row = out_row_r;
  assign out_bus.cursor_pos = out_pos_r;
  assign out_bus.cell_char  = out_char_r;
  assign out_bus.cell_attr  = out_attr_r;
  assign out_bus.did_scroll = out_scroll_r;

  `TMTW_AST_IMP(a_cursor_range, clk, rst_n, 1'b1, (cur_col_r < COL_W'(COLUMNS)) && (cur_row_r < ROW_W'(ROWS)))
  `TMTW_AST_IMP(a_top_range, clk, rst_n, 1'b1, top_r < ROW_W'(ROWS))
  `TMTW_AST_IMP(a_print_row_filled, clk, rst_n, cmd.print_wr, row_valid_r[prow_r])
  `TMTW_AST_IMP(a_load_out_free, clk, rst_n, cmd.load_out, !out_valid_r || out_bus.ready)
  `TMTW_AST_NXT(a_fill_sets_row, clk, rst_n, cmd.fill_wr && stat.fill_last, row_valid_r[prow_r])

endmodule

[src/text_mode_terminal_writer.sv]
// top level of the text mode terminal writer
// print, clear, color and blank reads: decode, act, done; next item taken once the result loads
// a printed cell in a row not filled since reset, clear or scroll first blanks the row in a fill pass
// read of a filled row in range adds a wait state for the registered ram read
// attribute follows the current color, so recoloring costs no sweep
// reset is synchronous; row valid flags make the whole screen read blank at once, no clearing pass
`timescale 1ns / 1ps
module text_mode_terminal_writer (
  input  logic        clk,
  input  logic        rst_n,
  tmtw_in_if.sink     in_bus,
  tmtw_out_if.source  out_bus
);
  import tmtw_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  tmtw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_bus.ready = in_ready;

  tmtw_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .item_kind      (in_bus.kind),
    .item_char_byte (in_bus.char_byte),
    .item_new_color (in_bus.new_color),
    .item_read_row  (in_bus.read_row),
    .item_read_col  (in_bus.read_col),
    .out_bus        (out_bus)
  );

endmodule

[test/text_mode_terminal_writer_tb.sv]
// testbench for the text mode terminal writer: directed and random beats against a screen model
`timescale 1ns / 1ps
module text_mode_terminal_writer_tb;
  import tmtw_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] pos;
    logic [BYTE_W-1:0] ch;
    logic [BYTE_W-1:0] attr;
    logic              scroll;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tmtw_in_if  in_if ();
  tmtw_out_if out_if ();

  text_mode_terminal_writer u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if)
  );

  always #5 clk = ~clk;

  // screen model state
  logic [15:0]       shadow_screen [CELLS];
  int                shadow_top;
  int                shadow_col;
  int                shadow_row;
  logic [BYTE_W-1:0] shadow_color;

  status_t expected_status [$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  bit      tx_idle_on = 1'b1;
  bit      rx_idle_on = 1'b1;
  bit      rx_hold = 1'b0;
  int      rx_stall_left = 0;

  function automatic int cell_index(int row, int col);
    return ((shadow_top + row) % ROWS) * COLUMNS + col;
  endfunction

  function automatic void reset_screen();
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = {RESET_COLOR, BLANK_CHAR};
    shadow_top = 0;
    shadow_col = 0;
    shadow_row = 0;
    shadow_color = RESET_COLOR;
  endfunction

  function automatic status_t advance_screen(kind_t k, logic [7:0] ch, logic [7:0] color,
                                             logic [4:0] rrow, logic [6:0] rcol);
    status_t st;
    int base;
    st.ch = '0;
    st.attr = '0;
    st.scroll = 1'b0;
    case (k)
      KIND_PRINT: begin
        if (ch == NL_BYTE) begin
          shadow_col = 0;
          shadow_row++;
        end else if (ch == BS_BYTE) begin
          if (shadow_col > 0) begin
            shadow_col--;
            shadow_screen[cell_index(shadow_row, shadow_col)] = {shadow_color, BLANK_CHAR};
          end
        end else begin
          shadow_screen[cell_index(shadow_row, shadow_col)] = {shadow_color, ch};
          shadow_col++;
        end
        if (shadow_col >= COLUMNS) begin
          shadow_col = 0;
          shadow_row++;
        end
        if (shadow_row >= ROWS) begin
          base = (shadow_top % ROWS) * COLUMNS;
          for (int c = 0; c < COLUMNS; c++) shadow_screen[base + c] = {shadow_color, BLANK_CHAR};
          shadow_top = (shadow_top + 1) % ROWS;
          shadow_row = ROWS - 1;
          st.scroll = 1'b1;
        end
      end
      KIND_READ: begin
        if (rrow < ROWS && rcol < COLUMNS) begin
          {st.attr, st.ch} = shadow_screen[cell_index(rrow, rcol)];
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_screen[i] = {shadow_color, BLANK_CHAR};
        shadow_top = 0;
        shadow_col = 0;
        shadow_row = 0;
      end
      default: begin
        shadow_color = color;
        for (int i = 0; i < CELLS; i++) shadow_screen[i][15:8] = shadow_color;
      end
    endcase
    st.col = shadow_col[COL_W-1:0];
    st.row = shadow_row[ROW_W-1:0];
    st.pos = 11'(shadow_row * COLUMNS + shadow_col);
    return st;
  endfunction

  function automatic void check_status();
    status_t want;
    if (expected_status.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("result beat with nothing expected");
      return;
    end
    want = expected_status.pop_front();
    if (out_if.cursor_col !== want.col || out_if.cursor_row !== want.row ||
        out_if.cursor_pos !== want.pos || out_if.cell_char !== want.ch ||
        out_if.cell_attr !== want.attr || out_if.did_scroll !== want.scroll) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch exp col %0d row %0d pos %0d char %02h attr %02h scroll %0b",
                 want.col, want.row, want.pos, want.ch, want.attr, want.scroll);
        $display("         got col %0d row %0d pos %0d char %02h attr %02h scroll %0b",
                 out_if.cursor_col, out_if.cursor_row, out_if.cursor_pos,
                 out_if.cell_char, out_if.cell_attr, out_if.did_scroll);
      end
    end
  endfunction

  // result side: check accepted beats, random stalls, long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_stall_left <= 0;
    end else begin
      if (out_if.valid && out_if.ready) check_status();
      if (rx_hold) begin
        out_if.ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left <= rx_stall_left - 1;
        out_if.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        rx_stall_left <= $urandom_range(1, 13) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_mode_terminal_writer test failed");
      $finish;
    end
  end

  task automatic send_item(kind_t k, logic [7:0] ch, logic [7:0] color,
                           logic [4:0] rrow, logic [6:0] rcol);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= k;
    in_if.char_byte <= ch;
    in_if.new_color <= color;
    in_if.read_row  <= rrow;
    in_if.read_col  <= rcol;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    expected_status.push_back(advance_screen(k, ch, color, rrow, rcol));
  endtask

  task automatic send_print(logic [7:0] ch);
    send_item(KIND_PRINT, ch, 8'($urandom), 5'($urandom), 7'($urandom));
  endtask

  task automatic send_read(logic [4:0] rrow, logic [6:0] rcol);
    send_item(KIND_READ, 8'($urandom), 8'($urandom), rrow, rcol);
  endtask

  task automatic send_color(logic [7:0] color);
    send_item(KIND_COLOR, 8'($urandom), color, 5'($urandom), 7'($urandom));
  endtask

  task automatic send_clear();
    send_item(KIND_CLEAR, 8'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
  endtask

  function automatic logic [7:0] text_byte(int nl_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < nl_pct) return NL_BYTE;
    if (r < nl_pct + 6) return BS_BYTE;
    if (r < nl_pct + 12) return 8'($urandom);
    return 8'($urandom_range(32, 126));
  endfunction

  task automatic send_random_item(int nl_pct, bit allow_clear);
    int pick;
    logic [4:0] rrow;
    logic [6:0] rcol;
    pick = $urandom_range(0, 99);
    rrow = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, ROWS - 1));
    rcol = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, COLUMNS - 1));
    if (pick < 74) send_print(text_byte(nl_pct));
    else if (pick < 94) send_read(rrow, rcol);
    else if (pick < 98 || !allow_clear) send_color(8'($urandom));
    else send_clear();
  endtask

  task automatic test_reset_screen();
    send_read(5'd0, 7'd0);
    send_read(5'(ROWS - 1), 7'(COLUMNS - 1));
    send_read(5'(ROWS), 7'd0);
    send_read(5'd0, 7'(COLUMNS));
    send_read(5'h1f, 7'h7f);
  endtask

  task automatic test_print_specials();
    send_print(BS_BYTE);
    send_print(8'hff);
    send_print(8'h00);
    send_print("A");
    send_print(BS_BYTE);
    send_read(5'd0, 7'd2);
    send_read(5'd0, 7'd1);
    send_print(NL_BYTE);
    send_read(5'd0, 7'd0);
  endtask

  task automatic test_color_and_clear();
    send_color(8'h00);
    send_read(5'd0, 7'd0);
    send_color(8'hff);
    send_read(5'd0, 7'd1);
    send_print("Z");
    send_clear();
    send_read(5'd0, 7'd0);
    send_color(RESET_COLOR);
  endtask

  task automatic test_wrap_and_scroll();
    repeat (90) send_random_item(0, 1'b0);
    repeat (150) send_random_item(25, 1'b0);
  endtask

  task automatic test_random_mix();
    repeat (400) send_random_item(12, 1'b1);
  endtask

  task automatic test_input_stall();
    tx_idle_on = 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (40) send_random_item(15, 1'b1);
    tx_idle_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (200) send_random_item(15, 1'b1);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = KIND_PRINT;
    in_if.char_byte = '0;
    in_if.new_color = '0;
    in_if.read_row = '0;
    in_if.read_col = '0;
    reset_screen();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_screen();
    test_print_specials();
    test_color_and_clear();
    test_wrap_and_scroll();
    test_random_mix();
    test_input_stall();
    test_back_to_back();
    in_if.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("text_mode_terminal_writer test passed");
    end else begin
      $display("text_mode_terminal_writer test failed");
    end
    $finish;
  end

endmodule
